// File: hw/rtl/indexed_list_store_assert.svh
// Assertion macros used by the indexed list store top level.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// Same-cycle implication, clocked by clk and disabled during reset.
`define ILS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked by clk and disabled during reset.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ils_pkg.sv
// Types and constants of the indexed list store.
package ils_pkg;

	localparam int KIND_W = 3;
	localparam int IDX_W  = 8;
	localparam int VAL_W  = 32;
	localparam int LEN_W  = 7;
	localparam int STAT_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND  = 3'd0,
		KIND_PREPEND = 3'd1,
		KIND_INSERT  = 3'd2,
		KIND_REMOVE  = 3'd3,
		KIND_GET     = 3'd4
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_SHIFT,
		S_INS_DRAIN,
		S_INS_WRITE,
		S_REM_SHIFT,
		S_GET_READ,
		S_FLUSH,
		S_RESP
	} state_t;

endpackage

// File: hw/rtl/indexed_list_store.sv
// Top level of the indexed list store: sequencer, entry memory and result register.
//
// Requests arrive on req_valid/req_stall with kind, index and value; each one
// gives exactly one result on rsp_valid/rsp_stall with status, read_value and
// length. A request is taken when valid is high and stall is low.
// The block works on one request at a time and holds req_stall high until it
// has placed that request's result in the output register.
// Insert and prepend move the entries behind the position one place up, one
// entry per cycle through the single memory port pair; when the position is
// the end, as for append, no entry moves. Remove moves the entries above the
// position down. Get reads the entry at the position, and a rejected request
// goes straight to its result. The next request is taken in the cycle after
// a result is loaded.
// While the receiver stalls, the result stays in the output register and a
// new request may be taken; its result waits until the register is free.
// Reset empties the store at once; entries are not cleared.
module indexed_list_store #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [ils_pkg::KIND_W-1:0]        kind,
	input  logic signed [ils_pkg::IDX_W-1:0]  index,
	input  logic signed [ils_pkg::VAL_W-1:0]  value,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [ils_pkg::STAT_W-1:0]        status,
	output logic signed [ils_pkg::VAL_W-1:0]  read_value,
	output logic [ils_pkg::LEN_W-1:0]         length
);
	import ils_pkg::*;

	`include "indexed_list_store_assert.svh"

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	state_t                  state_q;
	state_t                  state_d;
	logic [KIND_W-1:0]       kind_q;
	logic signed [IDX_W-1:0] index_q;
	logic [VAL_W-1:0]        value_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           cnt_m1;
	logic [CW-1:0]           pos_q;
	status_t                 st_q;
	logic [AW-1:0]           rd_ptr_q;
	logic [AW-1:0]           wr_addr_q;
	logic                    pend_q;
	logic                    first_q;
	logic [VAL_W-1:0]        rd_val_q;
	logic [VAL_W-1:0]        rdata_q;
	logic                    rsp_valid_q;
	status_t                 status_q;
	logic [VAL_W-1:0]        read_value_q;
	logic [LEN_W-1:0]        length_q;

	logic [CW-1:0]           map_pos;
	status_t                 map_code;
	logic                    rsp_load;
	logic                    rem_last;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [VAL_W-1:0]        mem_wdata;
	logic [VAL_W-1:0]        mem [CAPACITY];

	ils_index_map #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_map (
		.kind  (kind_q),
		.index (index_q),
		.count (count_q),
		.pos   (map_pos),
		.code  (map_code)
	);

	assign cnt_m1   = count_q - CW'(1);
	assign rem_last = (CW'(rd_ptr_q) == cnt_m1);
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (map_code != STAT_DONE) begin
					state_d = S_RESP;
				end else begin
					case (kind_q) inside
						KIND_APPEND, KIND_PREPEND, KIND_INSERT: begin
							state_d = (count_q != map_pos) ? S_INS_SHIFT : S_INS_WRITE;
						end
						KIND_REMOVE: state_d = S_REM_SHIFT;
						KIND_GET:    state_d = S_GET_READ;
						default:     state_d = S_RESP;
					endcase
				end
			end
			S_INS_SHIFT: begin
				if (rd_ptr_q == pos_q[AW-1:0]) begin
					state_d = S_INS_DRAIN;
				end
			end
			S_INS_DRAIN: state_d = S_INS_WRITE;
			S_INS_WRITE: state_d = S_RESP;
			S_REM_SHIFT: begin
				if (rem_last) begin
					state_d = S_FLUSH;
				end
			end
			S_GET_READ: state_d = S_FLUSH;
			S_FLUSH:    state_d = S_RESP;
			S_RESP: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = wr_addr_q;
		mem_wdata = rdata_q;
		unique case (state_q)
			S_IDLE:      req_stall = 1'b0;
			S_INS_SHIFT: mem_we = pend_q;
			S_INS_DRAIN: mem_we = 1'b1;
			S_INS_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = value_q;
			end
			S_REM_SHIFT: mem_we = pend_q && !first_q;
			S_FLUSH:     mem_we = !first_q;
			default:     mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INS_WRITE) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_FLUSH && kind_q == KIND_REMOVE) begin
				count_q <= cnt_m1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			kind_q  <= kind;
			index_q <= index;
			value_q <= value;
		end
		unique case (state_q)
			S_DECODE: begin
				pos_q    <= map_pos;
				st_q     <= map_code;
				rd_val_q <= '0;
				first_q  <= 1'b1;
				pend_q   <= 1'b0;
				case (kind_q) inside
					KIND_REMOVE, KIND_GET: rd_ptr_q <= map_pos[AW-1:0];
					default:               rd_ptr_q <= cnt_m1[AW-1:0];
				endcase
			end
			S_INS_SHIFT: begin
				pend_q    <= 1'b1;
				wr_addr_q <= rd_ptr_q + AW'(1);
				rd_ptr_q  <= rd_ptr_q - AW'(1);
			end
			S_REM_SHIFT: begin
				pend_q    <= 1'b1;
				wr_addr_q <= rd_ptr_q - AW'(1);
				rd_ptr_q  <= rd_ptr_q + AW'(1);
				if (pend_q && first_q) begin
					rd_val_q <= rdata_q;
					first_q  <= 1'b0;
				end
			end
			S_FLUSH: begin
				if (first_q) begin
					rd_val_q <= rdata_q;
				end
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			status_q     <= st_q;
			read_value_q <= rd_val_q;
			length_q     <= LEN_W'(count_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[rd_ptr_q];
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign length     = length_q;

	`ILS_ASSERT(a_count_max, 1'b1, count_q <= CW'(CAPACITY), "count exceeds capacity")
	`ILS_ASSERT_NEXT(a_count_step, 1'b1, count_q == $past(count_q) || count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1), "count moved by more than one")
	`ILS_ASSERT(a_reject_keeps, state_q == S_RESP && $past(state_q) == S_DECODE, $stable(count_q), "rejected request changed the length")
	`ILS_ASSERT(a_shift_bound, state_q == S_INS_SHIFT, CW'(rd_ptr_q) < count_q, "insert shift read beyond the stored entries")

endmodule

// File: hw/rtl/ils_index_map.sv
// Maps a request index to a store position and checks range and fullness.
module ils_index_map #(
	parameter int CAPACITY = 64,
	parameter int CW = 7
) (
	input  logic [ils_pkg::KIND_W-1:0]       kind,
	input  logic signed [ils_pkg::IDX_W-1:0] index,
	input  logic [CW-1:0]                    count,
	output logic [CW-1:0]                    pos,
	output ils_pkg::status_t                 code
);
	import ils_pkg::*;

	localparam int KW = ((CW > IDX_W) ? CW : IDX_W) + 2;

	logic signed [KW-1:0] k_s;
	logic signed [KW-1:0] l_s;
	logic signed [KW-1:0] lp1_s;
	logic signed [KW-1:0] neg_l_s;
	logic signed [KW-1:0] neg_lp1_s;
	logic signed [KW-1:0] sum_s;
	logic signed [KW-1:0] ins_s;
	logic                 is_full;
	logic                 is_empty;

	assign k_s       = {{(KW-IDX_W){index[IDX_W-1]}}, index};
	assign l_s       = {{(KW-CW){1'b0}}, count};
	assign lp1_s     = l_s + {{(KW-1){1'b0}}, 1'b1};
	assign neg_l_s   = -l_s;
	assign neg_lp1_s = -lp1_s;
	assign sum_s     = l_s + k_s;
	assign ins_s     = lp1_s + k_s;
	assign is_full   = (count == CW'(CAPACITY));
	assign is_empty  = (count == '0);

	always_comb begin
		pos  = '0;
		code = STAT_RANGE;
		unique case (kind)
			KIND_APPEND: begin
				pos  = count;
				code = is_full ? STAT_FULL : STAT_DONE;
			end
			KIND_PREPEND: begin
				code = is_full ? STAT_FULL : STAT_DONE;
			end
			KIND_INSERT: begin
				if (k_s >= 0 && k_s <= l_s) begin
					pos  = k_s[CW-1:0];
					code = is_full ? STAT_FULL : STAT_DONE;
				end else if (k_s < 0 && k_s >= neg_lp1_s) begin
					pos  = ins_s[CW-1:0];
					code = is_full ? STAT_FULL : STAT_DONE;
				end
			end
			KIND_REMOVE: begin
				if (!is_empty) begin
					if (k_s >= 0 && k_s < l_s) begin
						pos  = k_s[CW-1:0];
						code = STAT_DONE;
					end else if (k_s < 0 && k_s >= neg_l_s) begin
						pos  = sum_s[CW-1:0];
						code = STAT_DONE;
					end else if (k_s == neg_lp1_s) begin
						code = STAT_DONE;
					end
				end
			end
			KIND_GET: begin
				if (!is_empty) begin
					if (k_s >= 0 && k_s < l_s) begin
						pos  = k_s[CW-1:0];
						code = STAT_DONE;
					end else if (k_s < 0 && k_s >= neg_l_s) begin
						pos  = sum_s[CW-1:0];
						code = STAT_DONE;
					end
				end
			end
			default: begin
				code = STAT_RANGE;
			end
		endcase
	end

endmodule

// File: tb/tb.sv
// Self-checking testbench of the indexed list store with a mirrored list and a result scoreboard.
`timescale 1ns / 100ps

module tb;
	import ils_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam int SEGMENTS = 10;
	localparam int SEGMENT_ITEMS = 48;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int HOLD_OFF_AFTER = 120;
	localparam int REPORT_LIMIT = 10;
	localparam logic [KIND_W-1:0] KIND_FIRST_SPARE = 3'd5;
	localparam logic [KIND_W-1:0] KIND_LAST_SPARE = 3'd7;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} request_mix_t;

	typedef struct {
		status_t status;
		logic signed [VAL_W-1:0] read_value;
		logic [LEN_W-1:0] length;
	} list_result_t;

	class list_mirror;
		logic signed [VAL_W-1:0] slots [STORE_DEPTH];
		int count;
		list_result_t awaited [$];
		int mismatches;

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		function status_t grow(int at, logic signed [VAL_W-1:0] v);
			if (count >= STORE_DEPTH) return STAT_FULL;
			for (int i = count; i > at; i--) slots[i] = slots[i-1];
			slots[at] = v;
			count++;
			return STAT_DONE;
		endfunction

		function void take_request(logic [KIND_W-1:0] k, logic signed [IDX_W-1:0] idx,
				logic signed [VAL_W-1:0] v);
			list_result_t r;
			int pos;
			int len;
			int at;
			bit found;
			pos = idx;
			len = count;
			at = 0;
			found = 1'b0;
			r.status = STAT_RANGE;
			r.read_value = '0;
			case (k)
				KIND_APPEND: begin
					r.status = grow(count, v);
				end
				KIND_PREPEND: begin
					r.status = grow(0, v);
				end
				KIND_INSERT: begin
					if (pos >= 0 && pos <= len) begin
						at = pos;
						found = 1'b1;
					end else if (pos < 0 && pos >= -(len + 1)) begin
						at = len + 1 + pos;
						found = 1'b1;
					end
					if (found) r.status = grow(at, v);
				end
				KIND_REMOVE, KIND_GET: begin
					if (len > 0) begin
						if (pos >= 0 && pos < len) begin
							at = pos;
							found = 1'b1;
						end else if (pos < 0 && pos >= -len) begin
							at = len + pos;
							found = 1'b1;
						end else if (k == KIND_REMOVE && pos == -(len + 1)) begin
							at = 0;
							found = 1'b1;
						end
					end
					if (found) begin
						r.read_value = slots[at];
						r.status = STAT_DONE;
						if (k == KIND_REMOVE) begin
							for (int i = at; i + 1 < count; i++) slots[i] = slots[i+1];
							count--;
						end
					end
				end
				default: begin
				end
			endcase
			r.length = count[LEN_W-1:0];
			awaited.push_back(r);
		endfunction

		function void check_result(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] rd,
				logic [LEN_W-1:0] len);
			list_result_t e;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result status %0d value %0d length %0d",
						$realtime, st, rd, len);
				return;
			end
			e = awaited.pop_front();
			if (st !== e.status || rd !== e.read_value || len !== e.length) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: expected status %0d value %0d length %0d, got %0d %0d %0d",
						$realtime, e.status, e.read_value, e.length, st, rd, len);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic [KIND_W-1:0] kind;
	logic signed [IDX_W-1:0] index;
	logic signed [VAL_W-1:0] value;
	logic rsp_valid;
	logic rsp_stall;
	logic [STAT_W-1:0] status;
	logic signed [VAL_W-1:0] read_value;
	logic [LEN_W-1:0] length;

	list_mirror mirror = new();
	int sent = 0;
	int quiet_cycles = 0;
	bit steady_sender = 1'b0;
	bit held_long = 1'b0;
	request_mix_t plan [SEGMENTS] = '{MIX_GROW, MIX_GROW, MIX_EVEN, MIX_SHRINK, MIX_SHRINK,
		MIX_GROW, MIX_GROW, MIX_EVEN, MIX_SHRINK, MIX_EVEN};

	indexed_list_store #(.CAPACITY(STORE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.kind(kind),
		.index(index),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.read_value(read_value),
		.length(length)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int request_gap();
		int r;
		if (steady_sender) return 0;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind(request_mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return KIND_W'($urandom_range(KIND_FIRST_SPARE, KIND_LAST_SPARE));
		case (mix)
			MIX_GROW: begin
				if (r < 34) return KIND_APPEND;
				if (r < 58) return KIND_PREPEND;
				if (r < 88) return KIND_INSERT;
				if (r < 94) return KIND_REMOVE;
				return KIND_GET;
			end
			MIX_SHRINK: begin
				if (r < 10) return KIND_INSERT;
				if (r < 70) return KIND_REMOVE;
				if (r < 85) return KIND_GET;
				if (r < 92) return KIND_APPEND;
				return KIND_PREPEND;
			end
			default: begin
				if (r < 20) return KIND_APPEND;
				if (r < 36) return KIND_PREPEND;
				if (r < 56) return KIND_INSERT;
				if (r < 78) return KIND_REMOVE;
				return KIND_GET;
			end
		endcase
	endfunction

	function automatic int pick_index(logic [KIND_W-1:0] k);
		int len;
		int lo;
		int hi;
		int r;
		len = mirror.count;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			case (k)
				KIND_INSERT: begin
					lo = -(len + 1);
					hi = len;
				end
				KIND_REMOVE: begin
					lo = -(len + 1);
					hi = len - 1;
				end
				default: begin
					lo = -len;
					hi = len - 1;
				end
			endcase
			if (hi < lo) return 0;
			return lo + int'($urandom_range(0, hi - lo));
		end
		if (r < 85) begin
			case ($urandom_range(0, 4))
				0: return len;
				1: return len + 1;
				2: return -len;
				3: return -(len + 1);
				default: return -(len + 2);
			endcase
		end
		return $urandom_range(0, 255);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 12) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return -1;
				2: return 32'sh8000_0000;
				default: return 32'sh7fff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	task automatic issue(input logic [KIND_W-1:0] k, input int idx,
			input logic signed [VAL_W-1:0] v);
		int gap;
		gap = request_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		index <= idx[IDX_W-1:0];
		value <= v;
		do @(posedge clk); while (req_stall);
		mirror.take_request(k, idx[IDX_W-1:0], v);
		sent++;
	endtask

	initial begin
		logic [KIND_W-1:0] k;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		kind <= KIND_APPEND;
		index <= '0;
		value <= '0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		issue(KIND_GET, 0, 0);
		issue(KIND_REMOVE, -1, 0);
		issue(KIND_FIRST_SPARE, 0, 32'sh7fff_ffff);
		issue(KIND_INSERT, -1, 32'sh7fff_ffff);
		issue(KIND_APPEND, 127, 32'sh8000_0000);
		issue(KIND_PREPEND, -128, -1);
		issue(KIND_INSERT, 0, 32'sh5555_aaaa);
		issue(KIND_INSERT, mirror.count, 32'shaaaa_5555);
		issue(KIND_INSERT, -(mirror.count + 1), 1);
		issue(KIND_INSERT, mirror.count + 1, 2);
		issue(KIND_INSERT, -(mirror.count + 2), 3);
		issue(KIND_GET, -1, 0);
		issue(KIND_GET, -mirror.count, 0);
		issue(KIND_GET, mirror.count, 0);
		issue(KIND_GET, -(mirror.count + 1), 0);
		issue(KIND_GET, 127, 0);
		issue(KIND_GET, -128, 0);
		issue(KIND_REMOVE, -(mirror.count + 1), 0);
		issue(KIND_REMOVE, -mirror.count, 0);
		issue(KIND_REMOVE, mirror.count - 1, 0);
		issue(KIND_REMOVE, mirror.count, 0);
		issue(KIND_REMOVE, -(mirror.count + 2), 0);
		issue(KIND_FIRST_SPARE + 3'd1, -1, -1);
		issue(KIND_LAST_SPARE, 64, 0);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			steady_sender = (seg % 4 == 1);
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				k = pick_kind(plan[seg]);
				issue(k, pick_index(k), pick_value());
			end
		end
		req_valid <= 1'b0;

		while (mirror.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
			$display("** indexed_list_store: PASSED **");
		end else begin
			$display("** indexed_list_store: FAILED **");
		end
		$finish;
	end

	initial begin
		int r;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_long && sent >= HOLD_OFF_AFTER) begin
				// Hold the result side long enough for the block to back up into its input.
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				held_long = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					rsp_stall <= 1'b0;
					repeat (100) @(posedge clk);
				end else if (r < 55) begin
					rsp_stall <= 1'b0;
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end else if (r < 93) begin
					rsp_stall <= 1'b1;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end else begin
					rsp_stall <= 1'b1;
					repeat ($urandom_range(20, 60)) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid && !rsp_stall)
			mirror.check_result(status, read_value, length);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || arst_n !== 1'b1)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no request or result moved for %0d cycles", QUIET_LIMIT);
			$display("** indexed_list_store: FAILED **");
			$finish;
		end
	end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ils_pkg.sv
hw/rtl/ils_index_map.sv
hw/rtl/indexed_list_store.sv
tb/tb.sv
